// File: hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and fixed-point helpers for the short-term plasticity core.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned QW        = 16;
  localparam int unsigned FRAC      = 15;
  localparam int unsigned IDX_W     = 10;
  localparam logic [16:0] ONE_Q15   = 17'd32768;

  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_LOAD = 1'b1
  } stp_cmd_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] synapse_index;
    logic             spike;
    logic [QW-1:0]    base_release;
    logic [QW-1:0]    decay_dep;
    logic [QW-1:0]    decay_fac;
    logic [QW-1:0]    recover_dep;
    logic [QW-1:0]    recover_fac;
    logic [QW-1:0]    load_release;
    logic [QW-1:0]    load_resource;
  } stp_in_t;

  typedef struct packed {
    logic [QW-1:0] efficacy;
    logic [QW-1:0] new_release;
    logic [QW-1:0] new_resource;
  } stp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_FINISH
  } stp_state_t;

  // clamp a signed value to 0..1.0
  function automatic logic [QW-1:0] clamp_unit(input logic signed [21:0] v);
    logic [QW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({5'b0, ONE_Q15})) begin
      r = QW'(ONE_Q15);
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // saturate an unsigned Q1.15 value to 1.0
  function automatic logic [QW-1:0] sat_unit(input logic [QW-1:0] v);
    logic [QW-1:0] r;
    if ({1'b0, v} > ONE_Q15) begin
      r = QW'(ONE_Q15);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/synapse_short_term_plasticity_core.sv
// ----------------------------------------------------------------------------
// synapse_short_term_plasticity_core
// Per-synapse release probability and resource update, Q1.15 state in RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time. A step item passes through accept, RAM read,
// decay multiply, efficacy and facilitation multiply, then clamp and write
// back; a load item goes from accept to write back. When SYNAPSES is below
// 1024 and not a power of two, or is 1, the synapse index is first reduced
// modulo SYNAPSES by a reciprocal multiply and a subtract, in a reduce state.
// The result sits in an output register, so a new item is taken while the
// previous result waits. The two state RAMs are not cleared: stepping a
// synapse before loading it gives undefined values.
// ----------------------------------------------------------------------------
module synapse_short_term_plasticity_core #(
  parameter int SYNAPSES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_valid,
  output logic             step_ready,
  input  stp_pkg::stp_in_t step_item,
  output logic             result_valid,
  input  logic             result_ready,
  output stp_pkg::stp_out_t result_item
);

  import stp_pkg::*;

  localparam int AW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam bit IS_POW2 = ((SYNAPSES & (SYNAPSES - 1)) == 0);
  localparam bit NEED_MOD = (SYNAPSES < (1 << IDX_W)) && (!IS_POW2 || SYNAPSES == 1);
  // reciprocal of SYNAPSES, exact floor division for any index below 1024
  localparam int     RED_SH = IDX_W + ((SYNAPSES > 1) ? $clog2(SYNAPSES) : 0);
  localparam longint RED_M  = ((longint'(1) << RED_SH) + SYNAPSES - 1) / SYNAPSES;

  stp_state_t state, state_next;

  stp_in_t          item;
  logic [IDX_W-1:0] idx_rem;
  logic             red_bit;
  logic [IDX_W-1:0] red_quot;
  logic [21:0]      red_prod;
  logic [19:0]      red_back;
  logic [AW+IDX_W-1:0] addr_wide;
  logic [AW-1:0]    addr;

  logic [QW-1:0]    rd_u;
  logic [QW-1:0]    rd_x;
  logic [17:0]      u1;
  logic [17:0]      x1;
  logic [35:0]      eff_p;
  logic signed [35:0] sp_p;
  logic signed [18:0] one_minus_u;

  logic             out_free;
  logic             ram_re;
  logic             ram_we;
  logic [QW-1:0]    wr_u;
  logic [QW-1:0]    wr_x;
  logic [QW-1:0]    wr_eff;

  logic [20:0]      eff_q;
  logic [QW-1:0]    eff_sat;
  logic [35:0]      sp_mag;
  logic [20:0]      sp_sh;
  logic signed [21:0] sp_term;
  logic signed [21:0] u2;
  logic signed [21:0] x2;

  assign out_free  = !result_valid || result_ready;
  assign red_prod  = 22'(idx_rem) * 22'(RED_M);
  assign red_back  = 20'(red_quot) * 20'(SYNAPSES);
  assign addr_wide = {{AW{1'b0}}, idx_rem};
  assign addr      = addr_wide[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (step_valid) begin
          if (NEED_MOD) begin
            state_next = ST_REDUCE;
          end else if (step_item.cmd == CMD_LOAD) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_REDUCE: begin
        if (red_bit == '0) begin
          state_next = (item.cmd == CMD_LOAD) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    step_ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    case (state)
      ST_IDLE:   step_ready = 1'b1;
      ST_READ:   ram_re     = 1'b1;
      ST_FINISH: ram_we     = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and index reduction: quotient first, then remainder
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && step_valid) begin
      item    <= step_item;
      idx_rem <= step_item.synapse_index;
      red_bit <= 1'b1;
    end else if (state == ST_REDUCE) begin
      if (red_bit) begin
        red_quot <= IDX_W'(red_prod >> RED_SH);
      end else begin
        idx_rem <= IDX_W'({10'b0, idx_rem} - red_back);
      end
      red_bit <= 1'b0;
    end
  end

  stp_ram #(.WIDTH(QW), .DEPTH(SYNAPSES)) u_release_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wr_u),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rd_u)
  );

  stp_ram #(.WIDTH(QW), .DEPTH(SYNAPSES)) u_resource_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wr_x),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rd_x)
  );

  assign one_minus_u = $signed({2'b0, ONE_Q15}) - $signed({1'b0, u1});

  // relax, then efficacy and facilitation products
  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      u1 <= 18'((32'(rd_u) * 32'(item.decay_fac)) >> FRAC) + 18'(item.recover_fac);
      x1 <= 18'((32'(rd_x) * 32'(item.decay_dep)) >> FRAC) + 18'(item.recover_dep);
    end
    if (state == ST_MUL2) begin
      eff_p <= 36'(u1) * 36'(x1);
      sp_p  <= 36'($signed({1'b0, item.base_release}) * one_minus_u);
    end
  end

  // saturate, apply spike, clamp
  always_comb begin
    eff_q   = eff_p[35:15];
    eff_sat = (eff_q > 21'(ONE_Q15)) ? QW'(ONE_Q15) : eff_q[QW-1:0];
    sp_mag  = sp_p[35] ? 36'(-sp_p) : 36'(sp_p);
    sp_sh   = sp_mag[35:15];
    // truncate toward zero for a negative product
    sp_term = sp_p[35] ? -$signed({1'b0, sp_sh}) : $signed({1'b0, sp_sh});
    u2      = $signed({4'b0, u1});
    x2      = $signed({4'b0, x1});
    if (item.spike) begin
      u2 = u2 + sp_term;
      x2 = x2 - $signed({6'b0, eff_sat});
    end
    if (item.cmd == CMD_LOAD) begin
      wr_u   = sat_unit(item.load_release);
      wr_x   = sat_unit(item.load_resource);
      wr_eff = '0;
    end else begin
      wr_u   = clamp_unit(u2);
      wr_x   = clamp_unit(x2);
      wr_eff = eff_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ram_we) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      result_item.efficacy     <= wr_eff;
      result_item.new_release  <= wr_u;
      result_item.new_resource <= wr_x;
    end
  end

endmodule
